// ----- src/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg: shared types for the longest palindromic substring block
// Controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lps_pkg;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_READ,
		ST_CMP,
		ST_DONE
	} lps_state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic zero_best;
		logic init_search;
		logic setup;
		logic expand;
		logic close;
		logic advance;
		logic push;
	} lps_cmd_t;

	typedef struct packed {
		logic cand_done;
		logic pb_out;
		logic equal;
		logic can_expand;
		logic first_probe;
	} lps_status_t;

endpackage

// ----- src/lps_ctrl.sv -----
// ----------------------------------------------------------------------------
// lps_ctrl: controller for the palindrome search
// Loads bytes, then walks every center of both parities, probing the
// store one compare at a time, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lps_ctrl
	import lps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        last_symbol,
	input  logic        empty_string,
	input  logic        out_free,
	input  lps_status_t status,
	output logic        in_stall,
	output lps_cmd_t    cmd
);

	lps_state_t state_q;
	lps_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_LOAD);
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					if (empty_string) begin
						cmd.clear     = 1'b1;
						cmd.zero_best = 1'b1;
						state_d       = ST_DONE;
					end else begin
						cmd.load = 1'b1;
						if (last_symbol) begin
							cmd.init_search = 1'b1;
							state_d         = ST_START;
						end
					end
				end
			end
			ST_START: begin
				if (status.cand_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.setup = 1'b1;
					state_d   = ST_READ;
				end
			end
			ST_READ: begin
				if (status.pb_out) begin
					cmd.advance = 1'b1;
					state_d     = ST_START;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (!status.equal && status.first_probe) begin
					cmd.advance = 1'b1;
					state_d     = ST_START;
				end else if (status.equal && status.can_expand) begin
					cmd.expand = 1'b1;
					state_d    = ST_READ;
				end else begin
					cmd.close = 1'b1;
					state_d   = ST_START;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.push  = 1'b1;
					cmd.clear = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

// ----- src/lps_dp.sv -----
// ----------------------------------------------------------------------------
// lps_dp: datapath for the palindrome search
// Byte store with two registered read ports, probe pointers, candidate
// counters and the best-so-far registers.
// ----------------------------------------------------------------------------
module lps_dp
	import lps_pkg::*;
#(
	parameter int MAX_LEN = 256,
	parameter int AW      = $clog2(MAX_LEN),
	parameter int CW      = $clog2(MAX_LEN + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lps_cmd_t      cmd,
	input  logic [7:0]    symbol,
	output lps_status_t   status,
	output logic [AW-1:0] best_s,
	output logic [CW-1:0] best_l,
	output logic          ovf
);

	logic [7:0]    mem [MAX_LEN];
	logic [7:0]    rd_a_q;
	logic [7:0]    rd_b_q;
	logic [CW-1:0] len_q;
	logic          ovf_q;
	logic [CW-1:0] c_q;
	logic          kind_q;
	logic [AW-1:0] pa_q;
	logic [CW-1:0] pb_q;
	logic          first_q;
	logic [AW-1:0] best_s_q;
	logic [CW-1:0] best_l_q;

	logic          room;
	logic          equal;
	logic [CW-1:0] cand_l;
	logic [AW-1:0] cand_s;
	logic          better;

	assign room   = (len_q < CW'(MAX_LEN));
	assign equal  = (rd_a_q == rd_b_q);
	assign cand_l = equal ? (pb_q - CW'(pa_q) + CW'(1)) : (pb_q - CW'(pa_q) - CW'(1));
	assign cand_s = equal ? pa_q : (pa_q + AW'(1));
	assign better = (cand_l > best_l_q) || ((cand_l == best_l_q) && (cand_s < best_s_q));

	assign status.cand_done   = (c_q == len_q);
	assign status.pb_out      = (pb_q >= len_q);
	assign status.equal       = equal;
	assign status.can_expand  = (pa_q != '0) &&
		(({1'b0, pb_q} + (CW + 1)'(1)) < {1'b0, len_q});
	assign status.first_probe = first_q;

	assign best_s = best_s_q;
	assign best_l = best_l_q;
	assign ovf    = ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			mem[len_q[AW-1:0]] <= symbol;
		end
		rd_a_q <= mem[pa_q];
		rd_b_q <= mem[pb_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (room) begin
				len_q <= len_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_search) begin
			c_q      <= '0;
			kind_q   <= 1'b0;
			best_s_q <= '0;
			best_l_q <= '0;
		end else if (cmd.zero_best) begin
			best_s_q <= '0;
			best_l_q <= '0;
		end
		if (cmd.setup) begin
			pa_q    <= c_q[AW-1:0];
			pb_q    <= c_q + CW'(kind_q);
			first_q <= 1'b1;
		end
		if (cmd.expand) begin
			pa_q    <= pa_q - AW'(1);
			pb_q    <= pb_q + CW'(1);
			first_q <= 1'b0;
		end
		if (cmd.close && better) begin
			best_s_q <= cand_s;
			best_l_q <= cand_l;
		end
		if (cmd.advance || cmd.close) begin
			kind_q <= ~kind_q;
			if (kind_q) begin
				c_q <= c_q + CW'(1);
			end
		end
	end

endmodule

// ----- src/longest_palindromic_substring.sv -----
// ----------------------------------------------------------------------------
// longest_palindromic_substring: longest palindrome finder, top level
// Stores a byte string and reports start and length of its longest
// palindromic substring, leftmost on ties.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries symbol, last_symbol and
//   empty_string. Bytes transfer one per cycle while the block loads.
//   Bytes beyond MAX_LEN are dropped and flagged by truncated.
//   After the last byte, in_stall stays high during the search. Each
//   center candidate passes through ST_START, ST_READ and ST_CMP, and each
//   extra ring compared adds another ST_READ and ST_CMP; an even candidate
//   running past the end passes through ST_START and ST_READ only.
//   The loop is set by one pair of reads from the byte store per compare.
//   An empty_string transfer gives a zero result.
//   Output channel (out_valid/out_stall) carries one result per string from
//   an output register; a stalled result holds until it transfers, and
//   loading of the next string may proceed meanwhile.
//   Reset clears the stored length, the overflow flag and the output valid.
// ----------------------------------------------------------------------------
module longest_palindromic_substring
	import lps_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       last_symbol,
	input  logic       empty_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] best_start,
	output logic [8:0] best_length,
	output logic       truncated
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	lps_cmd_t      cmd;
	lps_status_t   status;
	logic          out_free;
	logic [AW-1:0] best_s;
	logic [CW-1:0] best_l;
	logic          ovf;
	logic          out_valid_q;
	logic [7:0]    best_start_q;
	logic [8:0]    best_length_q;
	logic          truncated_q;

	assign out_free = !out_valid_q || !out_stall;

	lps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.last_symbol  (last_symbol),
		.empty_string (empty_string),
		.out_free     (out_free),
		.status       (status),
		.in_stall     (in_stall),
		.cmd          (cmd)
	);

	lps_dp #(
		.MAX_LEN (MAX_LEN),
		.AW      (AW),
		.CW      (CW)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.symbol (symbol),
		.status (status),
		.best_s (best_s),
		.best_l (best_l),
		.ovf    (ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			best_start_q  <= 8'(best_s);
			best_length_q <= 9'(best_l);
			truncated_q   <= ovf;
		end
	end

	assign out_valid   = out_valid_q;
	assign best_start  = best_start_q;
	assign best_length = best_length_q;
	assign truncated   = truncated_q;

endmodule

// ----- src/lps_checker.sv -----
// ----------------------------------------------------------------------------
// lps_checker: port-level checks for the palindrome finder
// Watches the top level's channels and result fields over time.
// ----------------------------------------------------------------------------
module lps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       last_symbol,
	input logic       empty_string,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] best_start,
	input logic [8:0] best_length,
	input logic       truncated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(best_start) &&
			$stable(best_length) && $stable(truncated))
		else $error("stalled result changed");

	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (last_symbol || empty_string) |=> in_stall)
		else $error("input not held after end of string");

	a_zero_len_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (best_length == 9'd0) |-> (best_start == 8'd0))
		else $error("empty result with nonzero start");

	a_trunc_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> (best_length != 9'd0))
		else $error("truncated result with zero length");

endmodule

bind longest_palindromic_substring lps_checker u_lps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last_symbol  (last_symbol),
	.empty_string (empty_string),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.best_start   (best_start),
	.best_length  (best_length),
	.truncated    (truncated)
);
